>>> design/i2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Operator codes as they are kept on the operator stack.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5,
    OP_OPEN = 3'd6
  } op_e;

  localparam int unsigned OpWidth = 3;

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic [1:0] out_error;
  } out_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic op_e op_code(input logic [7:0] c);
    op_e r;
    unique case (c)
      CH_ADD:  r = OP_ADD;
      CH_SUB:  r = OP_SUB;
      CH_MUL:  r = OP_MUL;
      CH_DIV:  r = OP_DIV;
      CH_POW:  r = OP_POW;
      CH_OPEN: r = OP_OPEN;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prec(input op_e op);
    logic [1:0] r;
    unique case (op) inside
      OP_POW:         r = 2'd3;
      OP_MUL, OP_DIV: r = 2'd2;
      OP_ADD, OP_SUB: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_ascii(input op_e op);
    logic [7:0] r;
    unique case (op)
      OP_ADD:  r = CH_ADD;
      OP_SUB:  r = CH_SUB;
      OP_MUL:  r = CH_MUL;
      OP_DIV:  r = CH_DIV;
      OP_POW:  r = CH_POW;
      OP_OPEN: r = CH_OPEN;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Infix to postfix converter using the shunting-yard method. Characters of an
// infix expression arrive one per input transfer, the final one flagged by
// in_last; postfix characters leave one per output transfer, and the final
// result of each expression carries out_last. Letters pass through, the
// operators + - * / ^ and parentheses are reordered through an operator stack
// of STACK_DEPTH entries held in a single-port-read RAM, and other characters
// are dropped. A push onto a full stack reports out_error 1, a ')' without a
// matching '(' reports out_error 2; after an error the rest of the expression
// is skipped and its last character yields a single terminator result. The
// block takes one character at a time and holds in_stall_o high while it
// works on it. A letter or an ignored character goes from the idle state to
// the finish state. Every stack entry that is examined costs a RAM read and
// a compare by the shared precedence comparator, a push costs a state of its
// own, and a walk that runs down to an empty stack costs a further read that
// finds it empty. On the last character the flush then reads and compares
// each entry still stacked. After an error each skipped character is taken
// in the idle state alone, and the last one also passes the finish state.
// Output backpressure adds stalls on top.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire i2p_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output i2p_pkg::out_t       out_data_o
);

  import i2p_pkg::*;

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_PUSH = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // What the stack walk is doing for the current character.
  typedef enum logic [1:0] {
    M_CLOSE,
    M_OPER,
    M_FLUSH
  } mode_e;

  localparam out_t TermRes = '{out_char: CH_NUL, out_last: 1'b0, out_error: ERR_NONE};

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  op_e             code_q, code_d;
  logic            last_q, last_d;
  logic [CntW-1:0] count_q, count_d;
  logic            err_seen_q, err_seen_d;

  // The most recent result is held back one step, because only the end of a
  // character's work tells whether it is the final result of the expression.
  logic            hold_v_q, hold_v_d;
  out_t            hold_q, hold_d;
  logic            out_v_q, out_v_d;
  out_t            out_q, out_d;

  logic            in_xfer;
  logic            out_free;
  logic            can_emit;
  logic            ram_we;
  logic            ram_re;
  logic [CntW-1:0] cnt_m1;
  logic [OpWidth-1:0] ram_rdata;
  op_e             top_op;
  logic            pop_ok;
  logic            stack_full;
  op_e             in_op;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign out_free   = !out_v_q || !out_stall_i;
  assign can_emit   = !hold_v_q || out_free;
  assign cnt_m1     = count_q - 1'b1;
  assign top_op     = op_e'(ram_rdata);
  assign stack_full = (count_q >= CntW'(STACK_DEPTH));
  assign in_op      = op_code(in_data_i.in_char);

  // An operator pops the top while the top binds tighter, or equally tight
  // for the left-associative operators.
  assign pop_ok = (top_op != OP_OPEN) &&
                  ((prec(top_op) > prec(code_q)) ||
                   ((prec(top_op) == prec(code_q)) && (code_q != OP_POW)));

  assign ram_we = (state_q == S_PUSH) && !stack_full;
  assign ram_re = (state_q == S_RD) && (count_q != '0);

  i2p_ram #(
    .Width(OpWidth),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(code_q),
    .re_i   (ram_re),
    .raddr_i(cnt_m1[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    logic prod;
    out_t prod_res;
    logic fin_push;
    out_t fin_res;

    state_d    = state_q;
    mode_d     = mode_q;
    code_d     = code_q;
    last_d     = last_q;
    count_d    = count_q;
    err_seen_d = err_seen_q;
    prod       = 1'b0;
    prod_res   = TermRes;
    fin_push   = 1'b0;
    fin_res    = TermRes;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          last_d = in_data_i.in_last;
          code_d = in_op;
          if (err_seen_q) begin
            // The rest of a failed expression is skipped up to its end.
            if (in_data_i.in_last) begin
              err_seen_d = 1'b0;
              count_d    = '0;
              state_d    = S_FIN;
            end
          end else if (in_data_i.in_char == CH_CLOSE) begin
            mode_d  = M_CLOSE;
            state_d = S_RD;
          end else if (in_op == OP_OPEN) begin
            state_d = S_PUSH;
          end else if (in_op != OP_NONE) begin
            mode_d  = M_OPER;
            state_d = S_RD;
          end else begin
            if (is_letter(in_data_i.in_char)) begin
              // The hold stage is always empty between characters.
              prod              = 1'b1;
              prod_res.out_char = in_data_i.in_char;
            end
            mode_d  = M_FLUSH;
            state_d = in_data_i.in_last ? S_RD : S_FIN;
          end
        end
      end

      S_RD: begin
        if (count_q != '0) begin
          state_d = S_CHK;
        end else begin
          case (mode_q)
            M_CLOSE: begin
              if (can_emit) begin
                prod               = 1'b1;
                prod_res.out_error = ERR_UNMATCHED;
                count_d            = '0;
                err_seen_d         = !last_q;
                state_d            = S_FIN;
              end
            end
            M_OPER:  state_d = S_PUSH;
            default: state_d = S_FIN;
          endcase
        end
      end

      S_CHK: begin
        case (mode_q)
          M_CLOSE: begin
            if (top_op == OP_OPEN) begin
              count_d = cnt_m1;
              mode_d  = M_FLUSH;
              state_d = last_q ? S_RD : S_FIN;
            end else if (can_emit) begin
              prod              = 1'b1;
              prod_res.out_char = op_ascii(top_op);
              count_d           = cnt_m1;
              state_d           = S_RD;
            end
          end
          M_OPER: begin
            if (!pop_ok) begin
              state_d = S_PUSH;
            end else if (can_emit) begin
              prod              = 1'b1;
              prod_res.out_char = op_ascii(top_op);
              count_d           = cnt_m1;
              state_d           = S_RD;
            end
          end
          default: begin
            // Flush: an open parenthesis left at the end is dropped silently.
            if (top_op == OP_OPEN) begin
              count_d = cnt_m1;
              state_d = S_RD;
            end else if (can_emit) begin
              prod              = 1'b1;
              prod_res.out_char = op_ascii(top_op);
              count_d           = cnt_m1;
              state_d           = S_RD;
            end
          end
        endcase
      end

      S_PUSH: begin
        if (!stack_full) begin
          count_d = count_q + 1'b1;
          mode_d  = M_FLUSH;
          state_d = last_q ? S_RD : S_FIN;
        end else if (can_emit) begin
          prod               = 1'b1;
          prod_res.out_error = ERR_OVERFLOW;
          count_d            = '0;
          err_seen_d         = !last_q;
          state_d            = S_FIN;
        end
      end

      S_FIN: begin
        if (!last_q && !hold_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          // Release the held result; on the last character an empty hold
          // turns into a terminator result.
          fin_push         = 1'b1;
          fin_res          = hold_v_q ? hold_q : TermRes;
          fin_res.out_last = last_q;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    if (prod) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        out_v_d = 1'b1;
      end
      hold_d   = prod_res;
      hold_v_d = 1'b1;
    end
    if (fin_push) begin
      out_d    = fin_res;
      out_v_d  = 1'b1;
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_FLUSH;
      count_q    <= '0;
      err_seen_q <= 1'b0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      count_q    <= count_d;
      err_seen_q <= err_seen_d;
      hold_v_q   <= hold_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    last_q <= last_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

>>> design/i2p_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module i2p_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/i2p_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2p_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire i2p_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire i2p_pkg::out_t out_data_o
);

  import i2p_pkg::*;

  // A stalled character must wait unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transfer changed");

  // A stalled result must wait unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transfer changed");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_error == ERR_NONE) ||
                    (out_data_o.out_error == ERR_OVERFLOW) ||
                    (out_data_o.out_error == ERR_UNMATCHED))
    else $error("undefined error code on output");

  a_err_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_error != ERR_NONE) |-> out_data_o.out_char == CH_NUL)
    else $error("error result carries a character");

  a_out_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_char != CH_NUL) |->
      is_letter(out_data_o.out_char) || (out_data_o.out_char == CH_ADD) ||
      (out_data_o.out_char == CH_SUB) || (out_data_o.out_char == CH_MUL) ||
      (out_data_o.out_char == CH_DIV) || (out_data_o.out_char == CH_POW))
    else $error("output character is neither a letter nor an operator");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

>>> verif/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the shunting-yard infix to postfix converter.
//
// Characters are sent one per input transfer by a single sender task, and a
// behavioral predictor works out the postfix characters that each accepted
// character should produce. It keeps its own operator stack, depth counter
// and error flag. Those predictions wait in a queue. A separate checker
// process compares every output transfer, field by field, with the oldest
// prediction. A receiver process stalls the output at random, and on request
// holds it off for a long stretch so that the block fills up and stalls its
// input. A watchdog ends the run if no transfer happens on either side for
// too long.
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int unsigned StackDepth    = 32;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned RandomItems   = 24;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  infix_to_postfix_converter #(
    .STACK_DEPTH(StackDepth)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // Predicted postfix output, oldest first.
  out_t        expected_postfix_q[$];
  int unsigned error_count = 0;

  // Predictor state: operator stack, its fill level and the skip flag that
  // is set after an error until the last character of the expression.
  op_e         shadow_stack[StackDepth];
  int unsigned shadow_depth = 0;
  logic        skip_to_last = 1'b0;

  // Knobs shared between the test tasks and the receiver process.
  logic        sender_steady = 1'b0;
  logic        recv_steady   = 1'b0;
  int unsigned holdoff_left  = 0;

  // Scratch buffer for one generated expression.
  logic [7:0]  expr_chars[$];

  function automatic op_e char_to_op(logic [7:0] c);
    if (c == CH_ADD) return OP_ADD;
    if (c == CH_SUB) return OP_SUB;
    if (c == CH_MUL) return OP_MUL;
    if (c == CH_DIV) return OP_DIV;
    if (c == CH_POW) return OP_POW;
    if (c == CH_OPEN) return OP_OPEN;
    return OP_NONE;
  endfunction

  function automatic int unsigned op_rank(op_e op);
    case (op) inside
      OP_POW:         return 3;
      OP_MUL, OP_DIV: return 2;
      OP_ADD, OP_SUB: return 1;
      default:        return 0;
    endcase
  endfunction

  function automatic logic [7:0] op_glyph(op_e op);
    case (op)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic void append_expected(logic [7:0] c, logic [1:0] err);
    out_t r;
    r.out_char  = c;
    r.out_last  = 1'b0;
    r.out_error = err;
    expected_postfix_q.push_back(r);
  endfunction

  // Flags the newest prediction as the final result of its expression.
  function automatic void mark_final();
    out_t r;
    r = expected_postfix_q.pop_back();
    r.out_last = 1'b1;
    expected_postfix_q.push_back(r);
  endfunction

  // Works out what one accepted character produces and queues it.
  function automatic void predict_postfix(in_t item);
    int unsigned base;
    op_e         code;
    op_e         top;
    logic        matched;
    logic        failed;
    base    = expected_postfix_q.size();
    matched = 1'b0;
    failed  = 1'b0;

    // After an error everything is skipped; the last character closes the
    // expression with a single terminator.
    if (skip_to_last) begin
      if (item.in_last) begin
        skip_to_last = 1'b0;
        shadow_depth = 0;
        append_expected(CH_NUL, ERR_NONE);
        mark_final();
      end
      return;
    end

    if ((item.in_char >= "A" && item.in_char <= "Z") ||
        (item.in_char >= "a" && item.in_char <= "z")) begin
      append_expected(item.in_char, ERR_NONE);
    end else if (item.in_char == CH_CLOSE) begin
      while (shadow_depth > 0 && !matched) begin
        top = shadow_stack[shadow_depth - 1];
        shadow_depth--;
        if (top == OP_OPEN) begin
          matched = 1'b1;
        end else begin
          append_expected(op_glyph(top), ERR_NONE);
        end
      end
      if (!matched) begin
        append_expected(CH_NUL, ERR_UNMATCHED);
        failed = 1'b1;
      end
    end else begin
      code = char_to_op(item.in_char);
      if (code != OP_NONE) begin
        if (code != OP_OPEN) begin
          // Pop while the stacked operator binds tighter, or equally tight
          // when the new operator is left-associative.
          while (shadow_depth > 0) begin
            top = shadow_stack[shadow_depth - 1];
            if (top == OP_OPEN) break;
            if (op_rank(top) > op_rank(code) ||
                (op_rank(top) == op_rank(code) && code != OP_POW)) begin
              append_expected(op_glyph(top), ERR_NONE);
              shadow_depth--;
            end else begin
              break;
            end
          end
        end
        if (shadow_depth >= StackDepth) begin
          append_expected(CH_NUL, ERR_OVERFLOW);
          failed = 1'b1;
        end else begin
          shadow_stack[shadow_depth] = code;
          shadow_depth++;
        end
      end
    end

    if (failed) begin
      shadow_depth = 0;
      if (item.in_last) mark_final();
      else skip_to_last = 1'b1;
      return;
    end

    if (item.in_last) begin
      // Flush; open parentheses left on the stack are dropped silently.
      while (shadow_depth > 0) begin
        top = shadow_stack[shadow_depth - 1];
        shadow_depth--;
        if (top != OP_OPEN) append_expected(op_glyph(top), ERR_NONE);
      end
      if (expected_postfix_q.size() == base) append_expected(CH_NUL, ERR_NONE);
      mark_final();
    end
  endfunction

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int unsigned pick_idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] first;
    first = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return first + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Appends one character, sometimes preceded by a stray one: either any
  // byte at all or a character that breaks the structure of the expression.
  function automatic void add_char(logic [7:0] c, int unsigned noise_pct);
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 3))
        0:       expr_chars.push_back(CH_CLOSE);
        1:       expr_chars.push_back(CH_OPEN);
        2:       expr_chars.push_back(random_operator());
        default: expr_chars.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    expr_chars.push_back(c);
  endfunction

  // Builds an expression of the given number of operands, with random nesting
  // that may be left open, then disturbs it with noise at the given rate.
  function automatic void build_random_expr(int unsigned terms, int unsigned noise_pct);
    int unsigned open_cnt;
    open_cnt = 0;
    expr_chars.delete();
    for (int unsigned t = 0; t < terms; t++) begin
      while (open_cnt < 6 && $urandom_range(0, 3) == 0) begin
        add_char(CH_OPEN, noise_pct);
        open_cnt++;
      end
      add_char(random_letter(), noise_pct);
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CH_CLOSE, noise_pct);
        open_cnt--;
      end
      if (t + 1 < terms) add_char(random_operator(), noise_pct);
    end
    // Usually close what is still open; sometimes leave it for the flush.
    while (open_cnt > 0 && $urandom_range(0, 3) != 0) begin
      add_char(CH_CLOSE, noise_pct);
      open_cnt--;
    end
  endfunction

  // Sends one character and, once the transfer has happened, records what
  // it should produce. Returns right after the accepting rising edge.
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    in_t         item;
    gap = sender_steady ? 0 : pick_idle_len();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item.in_char = c;
    item.in_last = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_postfix(item);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr_chars();
    foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // Equal precedence with left association pops before the push.
  task automatic test_left_assoc();
    send_text("a-b+c");
  endtask

  // Right association of '^', nesting, and the letters A, Z and z at range ends.
  task automatic test_power_and_parens();
    send_text("(Z^A^z)");
  endtask

  // Multiply and divide, and an open parenthesis left for the flush to drop.
  task automatic test_open_at_end();
    send_text("(A*B/");
  endtask

  // Only ignored characters: the last one yields a bare terminator.
  task automatic test_ignored_chars();
    send_char(8'h00, 1'b0);
    send_char("{", 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // A stray ')' reports an error and the rest of the expression is skipped.
  task automatic test_unmatched_close();
    send_text(")AB");
  endtask

  // The error result itself is the final result of the expression.
  task automatic test_error_on_last();
    send_text("A)");
  endtask

  // Fills the operator stack exactly, then overflows it once in the middle
  // of an expression and once on its last character.
  task automatic test_stack_depth();
    for (int unsigned i = 0; i < StackDepth; i++) send_char(CH_OPEN, 1'b0);
    send_char("A", 1'b0);
    send_char(CH_CLOSE, 1'b1);

    send_char(random_letter(), 1'b0);
    for (int unsigned i = 0; i <= StackDepth; i++) begin
      send_char(CH_POW, 1'b0);
      send_char(random_letter(), 1'b0);
    end
    send_char("x", 1'b1);

    for (int unsigned i = 0; i <= StackDepth; i++) send_char(CH_OPEN, i == StackDepth);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    holdoff_left = HoldOffCycles;
    send_char(random_letter(), 1'b0);
    for (int unsigned i = 0; i < 20; i++) begin
      send_char(CH_POW, 1'b0);
      send_char(random_letter(), 1'b0);
    end
    send_char(CH_ADD, 1'b0);
    send_char(random_letter(), 1'b1);
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    sender_steady = 1'b1;
    recv_steady   = 1'b1;
    for (int unsigned n = 0; n < 5; n++) begin
      build_random_expr($urandom_range(2, 6), 0);
      send_expr_chars();
    end
    sender_steady = 1'b0;
    recv_steady   = 1'b0;
  endtask

  // Mostly well-formed expressions with random content; the rest carry
  // heavy noise and broken structure.
  task automatic test_random_expressions();
    int unsigned sent;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 99) < 80) build_random_expr($urandom_range(1, 8), 5);
      else build_random_expr($urandom_range(1, 6), 40);
      send_expr_chars();
      sent += expr_chars.size();
    end
  endtask

  // Receiver: the output stall changes only at the falling edge.
  initial begin
    int unsigned stall_run;
    stall_run = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_left != 0) begin
        out_stall <= 1'b1;
        holdoff_left--;
      end else if (recv_steady) begin
        out_stall <= 1'b0;
      end else if (stall_run != 0) begin
        stall_run--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        stall_run = pick_idle_len();
      end
    end
  end

  // Checker: every output transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_postfix_q.size() == 0) begin
        $error("unexpected output transfer: out_char %h out_last %b out_error %0d",
               out_data.out_char, out_data.out_last, out_data.out_error);
        error_count++;
      end else begin
        want = expected_postfix_q.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
          error_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
          error_count++;
        end
        if (out_data.out_error !== want.out_error) begin
          $error("out_error: expected %0d, got %0d", want.out_error, out_data.out_error);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block is hung.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $error("no transfer for %0d cycles, %0d results outstanding",
             quiet_cycles, expected_postfix_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_left_assoc();
    test_power_and_parens();
    test_open_at_end();
    test_ignored_chars();
    test_unmatched_close();
    test_error_on_last();
    test_stack_depth();
    test_backpressure();
    test_back_to_back();
    test_random_expressions();

    @(negedge clk);
    in_valid    <= 1'b0;
    recv_steady = 1'b1;
    while (expected_postfix_q.size() != 0) @(posedge clk);
    // Let any stray output show up before the verdict.
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0 && expected_postfix_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
